>>> hw/rtl/snnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snnm_pkg: shared types and constants
// Sizes of the line store, offsets and accumulators of the symmetric nearest
// neighbor mean filter.
// ----------------------------------------------------------------------------
package snnm_pkg;

  localparam int MAX_RADIUS  = 8;
  localparam int MAX_WIDTH   = 1024;
  localparam int CH_BITS     = 8;
  localparam int NUM_CH      = 4;

  localparam int WIN_ROWS    = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = WIN_ROWS * MAX_WIDTH;
  localparam int HEIGHT_MAX  = 4096;

  // Register field widths
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int RADCFG_W = 4;
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 13;
  localparam int IDX_W    = 2;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_MAX);
  localparam int SLOT_W  = $clog2(WIN_ROWS);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W   = RAD_W + 1;

  // Largest member count: point-symmetric pairs over the half plane
  localparam int CNT_MAX = 2 * MAX_RADIUS * MAX_RADIUS + 2 * MAX_RADIUS + 1;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SUM_W   = CNT_W + CH_BITS;
  localparam int DVD_W   = SUM_W + 1;
  localparam int DIST_W  = 2 * CH_BITS + 2;

  localparam int PIX_W   = NUM_CH * CH_BITS;

  // Channel 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [NUM_CH-1:0][CH_BITS-1:0] pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0]   sum_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_e;

  localparam logic [MODE_W-1:0] MODE_PAIRS = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV
  } state_e;

  // Tag that travels with each line store read
  typedef struct packed {
    logic centre_rd;   // read returns the centre pixel
    logic centre_add;  // add centre, last group of the window
    logic member;      // read returns a group member
    logic first;       // first member of its group
    logic last_mem;    // last member of its group
  } tag_t;

endpackage

>>> hw/rtl/symmetric_nearest_neighbour_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_nearest_neighbour_mean: streaming SNN mean filter, top level
// Takes a padded RGBA frame in raster order and emits the filtered interior.
// ----------------------------------------------------------------------------
// A pixel that yields no output is only written to the row memory. A pixel
// that completes a window walks G offset groups ((r+1)^2 for quadruples,
// 2r^2+2r+1 for pairs) with n members per group (4 or 2): all window reads
// go through the single read port of the row memory, one per cycle, and
// are followed by the divider. The finished pixel sits in an output
// register, so the next input is taken while it waits. Any register write
// restarts the frame at its first pixel. Memory contents need no clearing
// after reset.
// ----------------------------------------------------------------------------
module symmetric_nearest_neighbour_mean (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port
  input  logic                       cfg_we_i,
  input  logic [snnm_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [snnm_pkg::CFG_W-1:0] cfg_data_i,
  // Input pixels
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  // Filtered pixels
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                       m_axis_tlast   // frame_end
);

  localparam int CW = snnm_pkg::COL_W + 1;
  localparam int RW = snnm_pkg::ROW_W + 1;

  // Configuration registers
  logic [snnm_pkg::WIDTH_W-1:0]  width_q;
  logic [snnm_pkg::HEIGHT_W-1:0] height_q;
  logic [snnm_pkg::RADCFG_W-1:0] radius_q;
  logic [snnm_pkg::MODE_W-1:0]   mode_q;

  logic [snnm_pkg::WIDTH_W-1:0]  w_eff;
  logic [snnm_pkg::HEIGHT_W-1:0] h_eff;
  logic [snnm_pkg::RAD_W-1:0]    r_eff;
  logic                          pairs;

  logic [snnm_pkg::COL_W-1:0]    col_q;
  logic [snnm_pkg::ROW_W-1:0]    row_q;
  logic [snnm_pkg::SLOT_W-1:0]   slot_q;
  logic [CW-1:0]                 col_inc;
  logic [RW-1:0]                 row_inc;
  logic                          produce, last_pix, accept;

  snnm_pkg::state_e              state_q, state_d;
  logic                          seq_start, div_start, out_load, out_free;

  logic                          seq_busy, rd_en, acc_done, div_busy;
  logic [snnm_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
  snnm_pkg::tag_t                tag;
  snnm_pkg::pix_t                rd_pix, mean;
  snnm_pkg::sum_t                sums;
  logic [snnm_pkg::CNT_W-1:0]    cnt;

  logic                          frame_end_q, out_valid_q, out_last_q;
  snnm_pkg::pix_t                out_pix_q;

  // Effective register values
  always_comb begin
    if (width_q == '0) begin
      w_eff = snnm_pkg::WIDTH_W'(1);
    end else if (width_q > snnm_pkg::WIDTH_W'(snnm_pkg::MAX_WIDTH)) begin
      w_eff = snnm_pkg::WIDTH_W'(snnm_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = snnm_pkg::HEIGHT_W'(1);
    end else if (height_q > snnm_pkg::HEIGHT_W'(snnm_pkg::HEIGHT_MAX)) begin
      h_eff = snnm_pkg::HEIGHT_W'(snnm_pkg::HEIGHT_MAX);
    end else begin
      h_eff = height_q;
    end
    if (radius_q > snnm_pkg::RADCFG_W'(snnm_pkg::MAX_RADIUS)) begin
      r_eff = snnm_pkg::RAD_W'(snnm_pkg::MAX_RADIUS);
    end else begin
      r_eff = snnm_pkg::RAD_W'(radius_q);
    end
    pairs = (mode_q == snnm_pkg::MODE_PAIRS);
  end

  // Frame position
  always_comb begin
    col_inc  = CW'(col_q) + 1'b1;
    row_inc  = RW'(row_q) + 1'b1;
    produce  = (CW'(col_q) >= CW'({r_eff, 1'b0})) && (RW'(row_q) >= RW'({r_eff, 1'b0}));
    last_pix = (CW'(w_eff) == col_inc) && (RW'(h_eff) == row_inc);
    accept   = s_axis_tvalid && s_axis_tready;
    wr_addr  = snnm_pkg::ADDR_W'(slot_q) * snnm_pkg::ADDR_W'(snnm_pkg::MAX_WIDTH)
             + snnm_pkg::ADDR_W'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= snnm_pkg::WIDTH_W'(1024);
      height_q <= snnm_pkg::HEIGHT_W'(1024);
      radius_q <= snnm_pkg::RADCFG_W'(8);
      mode_q   <= snnm_pkg::MODE_W'(2);
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (snnm_pkg::reg_idx_e'(cfg_idx_i))
        snnm_pkg::REG_WIDTH:  width_q  <= cfg_data_i[snnm_pkg::WIDTH_W-1:0];
        snnm_pkg::REG_HEIGHT: height_q <= cfg_data_i[snnm_pkg::HEIGHT_W-1:0];
        snnm_pkg::REG_RADIUS: radius_q <= cfg_data_i[snnm_pkg::RADCFG_W-1:0];
        snnm_pkg::REG_MODE:   mode_q   <= cfg_data_i[snnm_pkg::MODE_W-1:0];
        default:              mode_q   <= mode_q;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (col_inc >= CW'(w_eff)) begin
        col_q <= '0;
        if (row_inc >= RW'(h_eff)) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_inc[snnm_pkg::ROW_W-1:0];
          slot_q <= (slot_q == snnm_pkg::SLOT_W'(snnm_pkg::WIN_ROWS - 1)) ? '0 : slot_q + 1'b1;
        end
      end else begin
        col_q <= col_inc[snnm_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_end_q <= last_pix;
    end
  end

  // Control: take a pixel, walk the window, divide, hand over
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    seq_start     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_free      = !out_valid_q || m_axis_tready;
    unique case (state_q)
      snnm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && produce) begin
          seq_start = 1'b1;
          state_d   = snnm_pkg::ST_RUN;
        end
      end
      snnm_pkg::ST_RUN: begin
        if (acc_done) begin
          div_start = 1'b1;
          state_d   = snnm_pkg::ST_DIV;
        end
      end
      snnm_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          state_d  = snnm_pkg::ST_IDLE;
        end
      end
      default: state_d = snnm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snnm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  snnm_line_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_addr),
    .wdata_i (snnm_pkg::pix_t'(s_axis_tdata)),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_pix)
  );

  snnm_group_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (seq_start),
    .radius_i  (r_eff),
    .pairs_i   (pairs),
    .col_i     (col_q),
    .slot_i    (slot_q),
    .busy_o    (seq_busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .tag_o     (tag)
  );

  snnm_select_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (seq_start),
    .tag_i   (tag),
    .pix_i   (rd_pix),
    .sum_o   (sums),
    .cnt_o   (cnt),
    .done_o  (acc_done)
  );

  snnm_mean_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sums),
    .cnt_i   (cnt),
    .busy_o  (div_busy),
    .mean_o  (mean)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= mean;
      out_last_q <= frame_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_seq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == snnm_pkg::ST_IDLE) |-> !seq_busy)
    else $error("window walk active while idle");

  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == snnm_pkg::ST_RUN))
    else $error("sums finished outside window walk");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output overwritten before it was taken");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");

endmodule

>>> hw/rtl/snnm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snnm_line_store: row memory
// Holds the last rows of the padded frame; one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module snnm_line_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [snnm_pkg::ADDR_W-1:0] waddr_i,
  input  snnm_pkg::pix_t              wdata_i,
  input  logic                        re_i,
  input  logic [snnm_pkg::ADDR_W-1:0] raddr_i,
  output snnm_pkg::pix_t              rdata_o
);

  snnm_pkg::pix_t mem_q [snnm_pkg::STORE_DEPTH];
  snnm_pkg::pix_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/snnm_group_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snnm_group_seq: window read sequencer
// Reads the centre, then every member of every offset group, one read per
// cycle, and tags each read for the selector.
// ----------------------------------------------------------------------------
module snnm_group_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [snnm_pkg::RAD_W-1:0]  radius_i,
  input  logic                        pairs_i,
  input  logic [snnm_pkg::COL_W-1:0]  col_i,
  input  logic [snnm_pkg::SLOT_W-1:0] slot_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [snnm_pkg::ADDR_W-1:0] rd_addr_o,
  output snnm_pkg::tag_t              tag_o
);

  localparam int CW = snnm_pkg::COL_W + 1;
  localparam int SW = snnm_pkg::SLOT_W + 1;

  logic                               busy_q, cen_q, pairs_q;
  logic        [snnm_pkg::RAD_W-1:0]  rad_q;
  logic        [snnm_pkg::COL_W-1:0]  col_q;
  logic        [snnm_pkg::SLOT_W-1:0] slot_q;
  logic signed [snnm_pkg::OFF_W-1:0]  u_q, v_q;
  logic        [1:0]                  i_q;
  snnm_pkg::tag_t                     tag_d, tag_q;

  logic signed [snnm_pkg::OFF_W-1:0]  rad_s, umax, du, dv;
  logic        [1:0]                  i_last;
  logic                               at_centre;
  logic signed [CW-1:0]               col_t;
  logic signed [SW-1:0]               roff, slot_t;
  logic        [snnm_pkg::SLOT_W-1:0] rd_slot;

  // Member offsets of the current group
  always_comb begin
    rad_s     = snnm_pkg::OFF_W'(rad_q);
    umax      = pairs_q ? rad_s : '0;
    i_last    = pairs_q ? 2'd1 : 2'd3;
    at_centre = (u_q == '0) && (v_q == '0);
    du        = u_q;
    dv        = v_q;
    case (i_q)
      2'd0:    begin du = u_q;  dv = v_q;  end
      2'd1:    begin du = -u_q; dv = -v_q; end
      2'd2:    begin du = -u_q; dv = v_q;  end
      default: begin du = u_q;  dv = -v_q; end
    endcase
    if (cen_q) begin
      du = '0;
      dv = '0;
    end
  end

  // Address: column col - r + du, row slot stepped back by r - dv modulo rows
  always_comb begin
    col_t  = CW'(col_q) - CW'(rad_q) + CW'(du);
    roff   = SW'(rad_s) - SW'(dv);
    slot_t = SW'(slot_q) - roff;
    if (slot_t < 0) begin
      slot_t = slot_t + SW'(snnm_pkg::WIN_ROWS);
    end
    rd_slot   = slot_t[snnm_pkg::SLOT_W-1:0];
    rd_addr_o = snnm_pkg::ADDR_W'(rd_slot) * snnm_pkg::ADDR_W'(snnm_pkg::MAX_WIDTH)
              + snnm_pkg::ADDR_W'(col_t[snnm_pkg::COL_W-1:0]);
    rd_en_o   = busy_q && (cen_q || !at_centre);
  end

  always_comb begin
    tag_d            = '0;
    tag_d.centre_rd  = busy_q && cen_q;
    tag_d.centre_add = busy_q && !cen_q && at_centre;
    tag_d.member     = busy_q && !cen_q && !at_centre;
    tag_d.first      = (i_q == 2'd0);
    tag_d.last_mem   = (i_q == i_last);
  end

  // Group walk: v rows from -r, u from -r to the row end, centre last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cen_q  <= 1'b0;
      tag_q  <= '0;
    end else begin
      tag_q <= tag_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cen_q  <= 1'b1;
      end else if (busy_q) begin
        if (cen_q) begin
          cen_q <= 1'b0;
        end else if (at_centre) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q   <= radius_i;
      pairs_q <= pairs_i;
      col_q   <= col_i;
      slot_q  <= slot_i;
    end else if (busy_q) begin
      if (cen_q) begin
        u_q <= -rad_s;
        v_q <= -rad_s;
        i_q <= 2'd0;
      end else if (!at_centre) begin
        if (i_q == i_last) begin
          i_q <= 2'd0;
          if (u_q == umax) begin
            u_q <= -rad_s;
            v_q <= v_q + 1'b1;
          end else begin
            u_q <= u_q + 1'b1;
          end
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign tag_o  = tag_q;

endmodule

>>> hw/rtl/snnm_select_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snnm_select_acc: nearest member select and channel sums
// Picks the member of each group closest to the centre in RGB distance and
// sums the picks with the centre.
// ----------------------------------------------------------------------------
module snnm_select_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  snnm_pkg::tag_t             tag_i,
  input  snnm_pkg::pix_t             pix_i,
  output snnm_pkg::sum_t             sum_o,
  output logic [snnm_pkg::CNT_W-1:0] cnt_o,
  output logic                       done_o
);

  snnm_pkg::pix_t                     cen_q, sel_q, chosen, add_pix;
  snnm_pkg::sum_t                     sum_q;
  logic [snnm_pkg::CNT_W-1:0]         cnt_q;
  logic [snnm_pkg::DIST_W-1:0]        best_q, cand_dist;
  logic                               better, add_en, done_q;
  logic signed [snnm_pkg::DIST_W-1:0] diff [3];

  // Squared RGB distance to the centre
  always_comb begin
    cand_dist = '0;
    for (int k = 0; k < 3; k++) begin
      diff[k]   = snnm_pkg::DIST_W'($signed({1'b0, pix_i[k]}) - $signed({1'b0, cen_q[k]}));
      cand_dist = cand_dist + snnm_pkg::DIST_W'($unsigned(diff[k] * diff[k]));
    end
    better  = tag_i.first || (cand_dist < best_q);
    chosen  = better ? pix_i : sel_q;
    add_en  = (tag_i.member && tag_i.last_mem) || tag_i.centre_add;
    add_pix = tag_i.centre_add ? cen_q : chosen;
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.centre_rd) begin
      cen_q <= pix_i;
    end
    if (tag_i.member && better) begin
      best_q <= cand_dist;
      sel_q  <= pix_i;
    end
    if (clear_i) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (add_en) begin
      for (int k = 0; k < snnm_pkg::NUM_CH; k++) begin
        sum_q[k] <= sum_q[k] + snnm_pkg::SUM_W'(add_pix[k]);
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag_i.centre_add;
    end
  end

  assign sum_o  = sum_q;
  assign cnt_o  = cnt_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/snnm_mean_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snnm_mean_div: rounded mean divider
// Restoring division of (sum + count/2) by count, one quotient bit per cycle,
// four channels side by side.
// ----------------------------------------------------------------------------
module snnm_mean_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  snnm_pkg::sum_t             sum_i,
  input  logic [snnm_pkg::CNT_W-1:0] cnt_i,
  output logic                       busy_o,
  output snnm_pkg::pix_t             mean_o
);

  localparam int STEP_W = $clog2(snnm_pkg::DVD_W + 1);
  localparam int NC     = snnm_pkg::NUM_CH;

  logic                       busy_q;
  logic [STEP_W-1:0]          step_q;
  logic [snnm_pkg::CNT_W-1:0] cnt_q;
  logic [snnm_pkg::DVD_W-1:0] dvd_q [NC];
  logic [snnm_pkg::DVD_W-1:0] quo_q [NC];
  logic [snnm_pkg::CNT_W-1:0] rem_q [NC];
  logic [snnm_pkg::CNT_W:0]   rem_sh [NC];
  logic                       qbit [NC];

  // One trial subtract per channel
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      rem_sh[k] = {rem_q[k], dvd_q[k][snnm_pkg::DVD_W-1]};
      qbit[k]   = (rem_sh[k] >= {1'b0, cnt_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(snnm_pkg::DVD_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= cnt_i;
      for (int k = 0; k < NC; k++) begin
        dvd_q[k] <= snnm_pkg::DVD_W'(sum_i[k]) + snnm_pkg::DVD_W'(cnt_i >> 1);
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (busy_q) begin
      for (int k = 0; k < NC; k++) begin
        dvd_q[k] <= dvd_q[k] << 1;
        quo_q[k] <= {quo_q[k][snnm_pkg::DVD_W-2:0], qbit[k]};
        if (qbit[k]) begin
          rem_q[k] <= snnm_pkg::CNT_W'(rem_sh[k] - {1'b0, cnt_q});
        end else begin
          rem_q[k] <= rem_sh[k][snnm_pkg::CNT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      mean_o[k] = quo_q[k][snnm_pkg::CH_BITS-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule
